FILE: sv/centered_score_association_assert.svh
// Assertion macros for the centered score association checks.
`ifndef CENTERED_SCORE_ASSOCIATION_ASSERT_SVH
`define CENTERED_SCORE_ASSOCIATION_ASSERT_SVH

// Check a property while out of reset.
`define CSA_CHECK(label, ck, rn, prop) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (prop)) \
        else $error("centered score association check failed");

// Check a property at every edge, reset included.
`define CSA_CHECK_ALWAYS(label, ck, prop) \
    label: assert property (@(posedge ck) (prop)) \
        else $error("centered score association check failed");

`endif

FILE: sv/csa_pkg.sv
// Shared types, codes and constants of the centered score association block.
package csa_pkg;

    localparam int MAX_SAMPLES_DEF  = 4096;
    localparam int MAX_FEATURES_DEF = 1048576;
    localparam int QUEUE_DEPTH      = 4;
    localparam int VAL_W            = 16;
    localparam int WGT_W            = 16;
    localparam int SCORE_W          = 64;
    localparam int IDX_W            = 20;
    localparam int ERR_W            = 2;

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_CLOSE  = 2'd1;
    localparam logic [1:0] CMD_ENTRY  = 2'd2;
    localparam logic [1:0] CMD_FINISH = 2'd3;

    localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_NO_LOAD = 2'd1;
    localparam logic [ERR_W-1:0] ERR_LENGTH  = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [VAL_W-1:0] value;
        logic [WGT_W-1:0]        weight;
    } cmd_t;

endpackage

FILE: sv/csa_front.sv
// Front end: classifies incoming items and queues them for the execution unit.
module csa_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        op,
    input  logic signed [15:0]          value,
    input  logic [15:0]                 weight,
    input  logic                        last,
    output logic                        cmd_valid,
    output csa_pkg::cmd_t               cmd,
    input  logic                        cmd_pop
);

    localparam int DEPTH = csa_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    csa_pkg::cmd_t   q_mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            wr_en;
    logic            rd_en;
    csa_pkg::cmd_t   in_cmd;

    always_comb
    begin
        full      = (cnt_reg == CNT_FULL);
        cmd_valid = (cnt_reg != '0);
        cmd       = q_mem[rd_ptr_reg];
        wr_en     = push && !full;
        rd_en     = cmd_pop && cmd_valid;

        if (op == 1'b0)
        begin
            in_cmd.kind = last ? csa_pkg::CMD_CLOSE : csa_pkg::CMD_SAMPLE;
        end
        else
        begin
            in_cmd.kind = last ? csa_pkg::CMD_FINISH : csa_pkg::CMD_ENTRY;
        end
        in_cmd.value  = value;
        in_cmd.weight = weight;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: sv/csa_div.sv
// Restoring divider, one quotient bit per cycle, for the phenotype mean.
module csa_div
#(
    parameter int N_W = 28,
    parameter int D_W = 13
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int SW = $clog2(N_W);
    localparam logic [SW-1:0] STEP_LAST = SW'(N_W - 1);

    logic [N_W-1:0] q_reg, q_next;
    logic [D_W-1:0] rem_reg, rem_next;
    logic [SW-1:0]  step_reg, step_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [D_W:0]   trial;
    logic [D_W:0]   diff;
    logic           ge;

    always_comb
    begin
        trial     = {rem_reg, q_reg[N_W-1]};
        diff      = trial - {1'b0, divisor};
        ge        = (trial >= {1'b0, divisor});
        q_next    = q_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[D_W-1:0] : trial[D_W-1:0];
            q_next    = {q_reg[N_W-2:0], ge};
            step_next = step_reg + SW'(1);
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        done     = done_reg;
        quotient = q_reg;
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

FILE: sv/csa_score.sv
// Score unit: squares the dot product and applies the weight on a shared multiplier.
module csa_score
#(
    parameter int ACC_W = 45
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [ACC_W-1:0]  acc,
    input  logic [15:0]              weight,
    output logic                     done,
    output logic [63:0]              score
);

    localparam int HALF   = (ACC_W + 1) / 2;
    localparam int NCHUNK = (2 * ACC_W + 31) / 32;
    localparam int SQP_W  = 32 * NCHUNK;
    localparam int TOT_W  = SQP_W + 16;
    localparam int KW     = $clog2(NCHUNK);

    localparam logic [2:0] SS_IDLE = 3'd0;
    localparam logic [2:0] SS_SQ0  = 3'd1;
    localparam logic [2:0] SS_SQ1  = 3'd2;
    localparam logic [2:0] SS_SQ2  = 3'd3;
    localparam logic [2:0] SS_SQ3  = 3'd4;
    localparam logic [2:0] SS_WMUL = 3'd5;
    localparam logic [2:0] SS_WADD = 3'd6;
    localparam logic [2:0] SS_DONE = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [ACC_W-1:0] m_reg, m_next;
    logic [15:0]      w_reg, w_next;
    logic [SQP_W-1:0] sq_reg, sq_next;
    logic [TOT_W-1:0] tot_reg, tot_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [63:0]      pp_reg;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [HALF-1:0]  lo;
    logic [ACC_W-HALF-1:0] hi;

    always_comb
    begin
        lo         = m_reg[HALF-1:0];
        hi         = m_reg[ACC_W-1:HALF];
        state_next = state_reg;
        m_next     = m_reg;
        w_next     = w_reg;
        sq_next    = sq_reg;
        tot_next   = tot_reg;
        k_next     = k_reg;
        mul_a      = 32'(lo);
        mul_b      = 32'(lo);
        case (state_reg)
            SS_IDLE:
            begin
                if (start)
                begin
                    m_next     = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
                    w_next     = weight;
                    state_next = SS_SQ0;
                end
            end
            SS_SQ0:
            begin
                state_next = SS_SQ1;
            end
            SS_SQ1:
            begin
                mul_b      = 32'(hi);
                sq_next    = SQP_W'(pp_reg);
                state_next = SS_SQ2;
            end
            SS_SQ2:
            begin
                mul_a      = 32'(hi);
                mul_b      = 32'(hi);
                sq_next    = sq_reg + (SQP_W'(pp_reg) << (HALF + 1));
                state_next = SS_SQ3;
            end
            SS_SQ3:
            begin
                sq_next    = sq_reg + (SQP_W'(pp_reg) << (2 * HALF));
                tot_next   = '0;
                k_next     = KW'(NCHUNK - 1);
                state_next = SS_WMUL;
            end
            SS_WMUL:
            begin
                mul_a      = sq_reg[SQP_W-1 -: 32];
                mul_b      = 32'(w_reg);
                sq_next    = sq_reg << 32;
                state_next = SS_WADD;
            end
            SS_WADD:
            begin
                tot_next = (tot_reg << 32) + TOT_W'(pp_reg);
                if (k_reg == '0)
                begin
                    state_next = SS_DONE;
                end
                else
                begin
                    k_next     = k_reg - KW'(1);
                    state_next = SS_WMUL;
                end
            end
            SS_DONE:
            begin
                state_next = SS_IDLE;
            end
            default:
            begin
                state_next = SS_IDLE;
            end
        endcase
        done  = (state_reg == SS_DONE);
        score = (|tot_reg[TOT_W-1:96]) ? '1 : tot_reg[95:32];
    end

    always_ff @(posedge clk)
    begin
        pp_reg  <= mul_a * mul_b;
        m_reg   <= m_next;
        w_reg   <= w_next;
        sq_reg  <= sq_next;
        tot_reg <= tot_next;
        k_reg   <= k_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/csa_exec.sv
// Execution unit: phenotype store, mean, centered dot product and result register.
module csa_exec
#(
    parameter int MAX_SAMPLES  = csa_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_FEATURES = csa_pkg::MAX_FEATURES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  csa_pkg::cmd_t       cmd,
    output logic                cmd_pop,
    output logic                empty,
    input  logic                pop,
    output logic [63:0]         score,
    output logic [19:0]         feature_index,
    output logic [1:0]          error_code
);

    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int POS_W = $clog2(MAX_SAMPLES + 2);
    localparam int SUM_W = 16 + AW;
    localparam int ACC_W = 33 + AW;
    localparam int FC_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_SAMPLES);
    localparam logic [POS_W-1:0] POS_SAT  = POS_W'(MAX_SAMPLES + 1);
    localparam logic [FC_W-1:0]  FC_LAST  = FC_W'(MAX_FEATURES - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIVGO = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;
    localparam logic [2:0] ST_SCORE = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic signed [15:0]      store_mem [MAX_SAMPLES];
    logic signed [15:0]      rd_data_reg;

    logic [2:0]              state_reg, state_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [15:0]      mean_reg, mean_next;
    logic                    loaded_reg, loaded_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [FC_W-1:0]         fc_reg, fc_next;
    csa_pkg::cmd_t           cur_reg, cur_next;
    logic signed [32:0]      prod_reg, prod_next;
    logic                    en_reg, en_next;
    logic [63:0]             res_score_reg, res_score_next;
    logic [1:0]              res_err_reg, res_err_next;
    logic                    out_valid_reg, out_valid_next;
    logic [63:0]             out_score_reg, out_score_next;
    logic [19:0]             out_idx_reg, out_idx_next;
    logic [1:0]              out_err_reg, out_err_next;

    logic                    out_free;
    logic                    out_load;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [SUM_W-1:0] base_sum;
    logic [CNT_W-1:0]        base_cnt;
    logic [SUM_W-1:0]        sum_mag;
    logic [SUM_W-1:0]        q_fix;
    logic signed [16:0]      centered;
    logic                    div_start;
    logic                    div_done;
    logic [SUM_W-1:0]        div_q;
    logic                    sc_start;
    logic                    sc_done;
    logic [63:0]             sc_score;

    csa_div
    #(
        .N_W (SUM_W),
        .D_W (CNT_W)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    csa_score
    #(
        .ACC_W (ACC_W)
    )
    u_score
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sc_start),
        .acc    (acc_reg),
        .weight (cur_reg.weight),
        .done   (sc_done),
        .score  (sc_score)
    );

    always_comb
    begin
        out_free  = !out_valid_reg || pop;
        out_load  = 1'b0;
        cmd_pop   = 1'b0;
        mem_we    = 1'b0;
        div_start = 1'b0;
        sc_start  = 1'b0;
        base_sum  = loaded_reg ? '0 : sum_reg;
        base_cnt  = loaded_reg ? '0 : cnt_reg;
        mem_waddr = base_cnt[AW-1:0];
        sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        q_fix     = sum_reg[SUM_W-1] ? SUM_W'(-div_q) : div_q;
        centered  = 17'(rd_data_reg) - 17'(mean_reg);

        state_next     = state_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        mean_next      = mean_reg;
        loaded_next    = loaded_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        fc_next        = fc_reg;
        cur_next       = cur_reg;
        prod_next      = prod_reg;
        en_next        = en_reg;
        res_score_next = res_score_reg;
        res_err_next   = res_err_reg;
        out_score_next = out_score_reg;
        out_idx_next   = out_idx_reg;
        out_err_next   = out_err_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind inside {csa_pkg::CMD_SAMPLE, csa_pkg::CMD_CLOSE})
                    begin
                        cmd_pop  = 1'b1;
                        sum_next = base_sum;
                        cnt_next = base_cnt;
                        if (loaded_reg)
                        begin
                            loaded_next = 1'b0;
                            pos_next    = '0;
                            acc_next    = '0;
                            fc_next     = '0;
                        end
                        if (base_cnt < CNT_MAX)
                        begin
                            mem_we   = 1'b1;
                            sum_next = base_sum + SUM_W'($signed(cmd.value));
                            cnt_next = base_cnt + CNT_W'(1);
                        end
                        if (cmd.kind == csa_pkg::CMD_CLOSE)
                        begin
                            pos_next   = '0;
                            acc_next   = '0;
                            fc_next    = '0;
                            state_next = ST_DIVGO;
                        end
                    end
                    else if (!loaded_reg)
                    begin
                        if (cmd.kind == csa_pkg::CMD_FINISH)
                        begin
                            if (out_free)
                            begin
                                cmd_pop        = 1'b1;
                                out_load       = 1'b1;
                                out_score_next = '0;
                                out_idx_next   = 20'(fc_reg);
                                out_err_next   = csa_pkg::ERR_NO_LOAD;
                            end
                        end
                        else
                        begin
                            cmd_pop = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd_pop    = 1'b1;
                        cur_next   = cmd;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mean_next   = (cnt_reg == '0) ? '0 : $signed(q_fix[15:0]);
                    loaded_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                prod_next  = $signed(cur_reg.value) * centered;
                en_next    = (pos_reg < POS_W'(cnt_reg));
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (en_reg)
                begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                if (pos_reg != POS_SAT)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
                state_next = (cur_reg.kind == csa_pkg::CMD_FINISH) ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                if (pos_reg != POS_W'(cnt_reg))
                begin
                    res_score_next = '0;
                    res_err_next   = csa_pkg::ERR_LENGTH;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    sc_start   = 1'b1;
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE:
            begin
                if (sc_done)
                begin
                    res_score_next = sc_score;
                    res_err_next   = csa_pkg::ERR_OK;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_score_next = res_score_reg;
                    out_idx_next   = 20'(fc_reg);
                    out_err_next   = res_err_reg;
                    fc_next        = (fc_reg == FC_LAST) ? '0 : fc_reg + FC_W'(1);
                    pos_next       = '0;
                    acc_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        empty         = !out_valid_reg;
        score         = out_score_reg;
        feature_index = out_idx_reg;
        error_code    = out_err_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= cmd.value;
        end
        rd_data_reg <= store_mem[pos_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        prod_reg      <= prod_next;
        en_reg        <= en_next;
        res_score_reg <= res_score_next;
        res_err_reg   <= res_err_next;
        out_score_reg <= out_score_next;
        out_idx_reg   <= out_idx_next;
        out_err_reg   <= out_err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            mean_reg      <= '0;
            loaded_reg    <= 1'b0;
            pos_reg       <= '0;
            acc_reg       <= '0;
            fc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            mean_reg      <= mean_next;
            loaded_reg    <= loaded_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            fc_reg        <= fc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/centered_score_association.sv
// Top level of the centered score association block.
//
// Input side is a queue: drive op, value, weight and last and raise push;
// the transfer happens on a clock edge with push high and full low. op 0
// loads a phenotype sample, op 1 streams a genotype entry of the current
// feature column; last closes the load or the column.
// Result side is a one-entry register: while empty is low, score,
// feature_index and error_code show the result; pop high on an edge takes it.
// A four-entry command queue sits between the input and the execution unit.
// Last phenotype sample: the restoring divider then forms the mean,
// one quotient bit per cycle.
// Genotype entry: store read, multiply, accumulate.
// Last entry: the shared 32x32 multiplier then forms the square
// and applies the weight in partial products.
// Reset clears all control state; the sample store holds no valid data.
// A stalled receiver holds the result register; the unit then waits with
// the next result, the command queue fills and full rises.
module centered_score_association
#(
    parameter int MAX_SAMPLES  = csa_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_FEATURES = csa_pkg::MAX_FEATURES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               op,
    input  logic signed [15:0] value,
    input  logic [15:0]        weight,
    input  logic               last,
    output logic               empty,
    input  logic               pop,
    output logic [63:0]        score,
    output logic [19:0]        feature_index,
    output logic [1:0]         error_code
);

    logic          cmd_valid;
    csa_pkg::cmd_t cmd;
    logic          cmd_pop;

    csa_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .op        (op),
        .value     (value),
        .weight    (weight),
        .last      (last),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    csa_exec
    #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .MAX_FEATURES (MAX_FEATURES)
    )
    u_exec
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .empty         (empty),
        .pop           (pop),
        .score         (score),
        .feature_index (feature_index),
        .error_code    (error_code)
    );

endmodule

FILE: sv/csa_checker.sv
// Port-level checks of the centered score association block and their binding.
`include "centered_score_association_assert.svh"

module csa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [63:0] score,
    input logic [19:0] feature_index,
    input logic [1:0]  error_code
);

    logic [85:0] result_bus;

    assign result_bus = {score, feature_index, error_code};

    `CSA_CHECK_ALWAYS(a_reset_clears, clk, (!rst_n) |=> (empty && !full))
    `CSA_CHECK(a_result_holds, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(result_bus)))
    `CSA_CHECK(a_code_known, clk, rst_n, (!empty) |-> (error_code <= csa_pkg::ERR_LENGTH))
    `CSA_CHECK(a_error_zero_score, clk, rst_n, (!empty && error_code != csa_pkg::ERR_OK) |-> (score == 64'd0))

endmodule

bind centered_score_association csa_checker u_csa_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .score         (score),
    .feature_index (feature_index),
    .error_code    (error_code)
);

FILE: tb/sv/tb_centered_score_association.sv
`timescale 1ns / 100ps
// Self-checking testbench for the centered score association block.
module tb_centered_score_association;

    localparam logic OP_SAMPLE       = 1'b0;
    localparam logic OP_ENTRY        = 1'b1;
    localparam int   IDLE_LIMIT      = 2000;
    localparam int   SETTLE_CYCLES   = 80;
    localparam int   RANDOM_ITEMS    = 1600;
    localparam int   EXTREME_SAMPLES = 64;

    typedef struct packed {
        logic [csa_pkg::SCORE_W-1:0] score;
        logic [csa_pkg::IDX_W-1:0]   index;
        logic [csa_pkg::ERR_W-1:0]   err;
    } score_rec_t;

    class association_board;
        logic signed [csa_pkg::VAL_W-1:0] samples [csa_pkg::MAX_SAMPLES_DEF];
        longint      sum;
        int unsigned count;
        longint      mean;
        bit          loaded;
        int unsigned position;
        longint      dot;
        int unsigned feature;
        score_rec_t  expected_scores[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned loads;

        function new();
            sum        = 0;
            count      = 0;
            mean       = 0;
            loaded     = 1'b0;
            mismatches = 0;
            checked    = 0;
            loads      = 0;
            clear_columns();
        endfunction

        function void clear_columns();
            position = 0;
            dot      = 0;
            feature  = 0;
        endfunction

        function logic [csa_pkg::SCORE_W-1:0] weighted_square(longint d,
                                                              logic [csa_pkg::WGT_W-1:0] w);
            logic [127:0] mag;
            logic [127:0] prod;
            mag  = (d < 0) ? 128'(-d) : 128'(d);
            prod = mag * mag * 128'(w);
            if (prod[127:96] != '0)
            begin
                return '1;
            end
            return prod[95:32];
        endfunction

        function void note_input(logic op_i, logic signed [csa_pkg::VAL_W-1:0] val,
                                 logic [csa_pkg::WGT_W-1:0] wgt, logic last_i);
            score_rec_t rec;
            if (op_i == OP_SAMPLE)
            begin
                if (loaded)
                begin
                    loaded = 1'b0;
                    sum    = 0;
                    count  = 0;
                    clear_columns();
                end
                if (count < csa_pkg::MAX_SAMPLES_DEF)
                begin
                    samples[count] = val;
                    sum += longint'(val);
                    count++;
                end
                if (last_i)
                begin
                    mean   = (count != 0) ? sum / longint'(count) : 0;
                    loaded = 1'b1;
                    loads++;
                    clear_columns();
                end
                return;
            end
            if (!loaded)
            begin
                if (last_i)
                begin
                    rec.score = '0;
                    rec.index = feature[csa_pkg::IDX_W-1:0];
                    rec.err   = csa_pkg::ERR_NO_LOAD;
                    expected_scores.push_back(rec);
                end
                return;
            end
            if (position < count)
            begin
                dot += longint'(val) * (longint'(samples[position]) - mean);
            end
            if (position <= csa_pkg::MAX_SAMPLES_DEF)
            begin
                position++;
            end
            if (!last_i)
            begin
                return;
            end
            if (position != count)
            begin
                rec.score = '0;
                rec.err   = csa_pkg::ERR_LENGTH;
            end
            else
            begin
                rec.score = weighted_square(dot, wgt);
                rec.err   = csa_pkg::ERR_OK;
            end
            rec.index = feature[csa_pkg::IDX_W-1:0];
            expected_scores.push_back(rec);
            feature++;
            if (feature >= csa_pkg::MAX_FEATURES_DEF)
            begin
                feature = 0;
            end
            position = 0;
            dot      = 0;
        endfunction

        function void check_result(logic [csa_pkg::SCORE_W-1:0] s,
                                   logic [csa_pkg::IDX_W-1:0] idx,
                                   logic [csa_pkg::ERR_W-1:0] e);
            score_rec_t rec;
            checked++;
            if (expected_scores.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: score %0d index %0d error %0d",
                         $time, s, idx, e);
                return;
            end
            rec = expected_scores.pop_front();
            if (s !== rec.score)
            begin
                mismatches++;
                $display("%0t: score expected %0d actual %0d", $time, rec.score, s);
            end
            if (idx !== rec.index)
            begin
                mismatches++;
                $display("%0t: feature_index expected %0d actual %0d", $time, rec.index, idx);
            end
            if (e !== rec.err)
            begin
                mismatches++;
                $display("%0t: error_code expected %0d actual %0d", $time, rec.err, e);
            end
        endfunction
    endclass

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               push  = 1'b0;
    logic               full;
    logic               op    = 1'b0;
    logic signed [15:0] value = '0;
    logic [15:0]        weight = '0;
    logic               last  = 1'b0;
    logic               empty;
    logic               pop   = 1'b0;
    logic [63:0]        score;
    logic [19:0]        feature_index;
    logic [1:0]         error_code;

    association_board board = new();
    bit          steady = 1'b0;
    int unsigned sent = 0;
    int unsigned idle_cycles = 0;

    centered_score_association dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .op            (op),
        .value         (value),
        .weight        (weight),
        .last          (last),
        .empty         (empty),
        .pop           (pop),
        .score         (score),
        .feature_index (feature_index),
        .error_code    (error_code)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 511)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd256;
            2: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(logic op_i, logic signed [15:0] val, logic [15:0] wgt,
                             logic last_i);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        op     <= op_i;
        value  <= val;
        weight <= wgt;
        last   <= last_i;
        @(posedge clk);
        while (full) @(posedge clk);
        board.note_input(op_i, val, wgt, last_i);
        sent++;
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (board.expected_scores.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_phenotype(int n);
        for (int i = 0; i < n; i++)
        begin
            send_item(OP_SAMPLE, pick_value(), 16'($urandom), i == n - 1);
        end
    endtask

    task automatic stream_column(int n, logic [15:0] wgt);
        for (int i = 0; i < n; i++)
        begin
            send_item(OP_ENTRY, pick_value(), (i == n - 1) ? wgt : 16'($urandom), i == n - 1);
        end
    endtask

    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            board.check_result(score, feature_index, error_code);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int r;
        int n;
        int unsigned random_start;
        logic [15:0] wgt;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_item(OP_ENTRY, 16'sh0100, 16'd256, 1'b0);
        send_item(OP_ENTRY, 16'sh0100, 16'd256, 1'b1);
        send_item(OP_SAMPLE, 16'sh7fff, 16'd0, 1'b0);
        send_item(OP_ENTRY, 16'sh8000, 16'hffff, 1'b1);
        send_item(OP_SAMPLE, 16'sh8000, 16'd0, 1'b0);
        send_item(OP_SAMPLE, 16'sh0100, 16'hffff, 1'b1);
        send_item(OP_ENTRY, 16'sh8000, 16'd0, 1'b0);
        send_item(OP_ENTRY, 16'sh7fff, 16'd0, 1'b0);
        send_item(OP_ENTRY, 16'sh0001, 16'hffff, 1'b1);
        send_item(OP_ENTRY, 16'sh7fff, 16'd0, 1'b0);
        send_item(OP_ENTRY, 16'sh7fff, 16'd256, 1'b1);
        send_item(OP_ENTRY, 16'sh7fff, 16'd0, 1'b0);
        send_item(OP_ENTRY, 16'sh8000, 16'd0, 1'b0);
        send_item(OP_ENTRY, 16'sh7fff, 16'd0, 1'b0);
        send_item(OP_ENTRY, 16'sh8000, 16'd256, 1'b1);
        send_item(OP_ENTRY, 16'sh7fff, 16'd0, 1'b0);
        send_item(OP_ENTRY, 16'sh8000, 16'd0, 1'b0);
        send_item(OP_ENTRY, 16'sh7fff, 16'd0, 1'b1);
        send_item(OP_ENTRY, 16'sh1234, 16'd0, 1'b0);
        send_item(OP_SAMPLE, 16'shfffd, 16'd0, 1'b0);
        send_item(OP_SAMPLE, 16'shfffe, 16'd0, 1'b1);
        send_item(OP_ENTRY, 16'sh0300, 16'd0, 1'b0);
        send_item(OP_ENTRY, 16'shfd00, 16'd256, 1'b1);
        drain_results();

        steady = 1'b1;
        for (int i = 0; i < EXTREME_SAMPLES; i++)
        begin
            send_item(OP_SAMPLE, (i % 2 == 0) ? 16'sh7fff : 16'sh8000,
                      16'd0, i == EXTREME_SAMPLES - 1);
        end
        for (int k = 0; k < 2; k++)
        begin
            wgt = (k == 0) ? 16'hffff : 16'd256;
            for (int i = 0; i < EXTREME_SAMPLES; i++)
            begin
                send_item(OP_ENTRY, (i % 2 == 0) ? 16'sh7fff : 16'sh8000, wgt,
                          i == EXTREME_SAMPLES - 1);
            end
        end
        stream_column(EXTREME_SAMPLES + 4, 16'd256);
        steady = 1'b0;
        drain_results();

        random_start = sent;
        load_phenotype($urandom_range(1, 24));
        while (sent < random_start + RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                load_phenotype($urandom_range(1, 24));
            end
            else if (r < 80)
            begin
                stream_column((board.count == 0) ? 1 : int'(board.count), pick_weight());
            end
            else if (r < 90)
            begin
                n = int'(board.count) + int'($urandom_range(0, 6)) - 3;
                stream_column((n < 1) ? 1 : n, pick_weight());
            end
            else if (r < 93)
            begin
                drain_results();
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_item(1'($urandom_range(0, 1)), pick_value(), pick_weight(),
                              $urandom_range(0, 3) == 0);
                end
            end
        end
        steady = 1'b0;
        drain_results();

        $display("Run: %0d items, %0d phenotype loads, %0d results checked, %0d mismatches",
                 sent, board.loads, board.checked, board.mismatches);
        $display("Run: edge cases, a %0d-sample extreme load, full-weight and bad-length columns",
                 EXTREME_SAMPLES);
        if (board.mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

FILE: centered_score_association.f
+incdir+sv
sv/csa_pkg.sv
sv/csa_front.sv
sv/csa_div.sv
sv/csa_score.sv
sv/csa_exec.sv
sv/centered_score_association.sv
sv/csa_checker.sv
tb/sv/tb_centered_score_association.sv
